// File: hw/rtl/bsrs_pkg.sv
// Shared definitions for the bounded set with rank select.
// Holds command codes, fixed port widths, parameter defaults and the cell control type.
// No dependencies.
package bsrs_pkg;

    localparam int CAPACITY_DEF  = 32;
    localparam int KEY_WIDTH_DEF = 32;

    localparam int CMD_W      = 2;
    localparam int PORT_KEY_W = 32;
    localparam int RANK_W     = 8;
    localparam int COUNT_W    = 6;

    localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ERASE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CONTAINS = 2'd2;
    localparam logic [CMD_W-1:0] CMD_GET      = 2'd3;

    typedef struct packed {
        logic probe_load;
        logic probe_shift;
        logic erase;
        logic rank_mode;
        logic write;
    } bsrs_cell_ctrl_t;

endpackage

// File: hw/rtl/bsrs_in_if.sv
// Command channel of the bounded set with rank select.
// Carries valid, ready and the command payload. Depends on bsrs_pkg.
interface bsrs_in_if;
    import bsrs_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [PORT_KEY_W-1:0] key;
    logic [RANK_W-1:0] rank_index;

    modport source (output valid, output cmd, output key, output rank_index, input ready);
    modport sink   (input valid, input cmd, input key, input rank_index, output ready);
endinterface

// File: hw/rtl/bsrs_out_if.sv
// Result channel of the bounded set with rank select.
// Carries valid, ready and the result payload. Depends on bsrs_pkg.
interface bsrs_out_if;
    import bsrs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  ok;
    logic [PORT_KEY_W-1:0] item_value;
    logic [COUNT_W-1:0]    item_count;

    modport source (output valid, output ok, output item_value, output item_count, input ready);
    modport sink   (input valid, input ok, input item_value, input item_count, output ready);
endinterface

// File: hw/rtl/bsrs_cell.sv
// One cell of the set: holds one stored key, a circulating probe used to rank it,
// and one stage of the sweep that searches, erases and selects. Depends on bsrs_pkg.
module bsrs_cell #(
    parameter int KW = bsrs_pkg::KEY_WIDTH_DEF,
    parameter int CW = $clog2(bsrs_pkg::CAPACITY_DEF + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bsrs_pkg::bsrs_cell_ctrl_t  ctrl,
    input  logic [KW-1:0]              cmd_key,
    input  logic [bsrs_pkg::RANK_W-1:0] rank_index,
    input  logic [CW-1:0]              held_count,
    input  logic [CW-1:0]              cell_index,
    input  logic [KW-1:0]              right_key,
    output logic [KW-1:0]              key_out,
    input  logic [KW-1:0]              probe_in,
    input  logic                       probe_valid_in,
    output logic [KW-1:0]              probe_out,
    output logic                       probe_valid_out,
    input  logic                       link_valid_in,
    input  logic                       link_found_in,
    input  logic [KW-1:0]              link_value_in,
    output logic                       link_valid_out,
    output logic                       link_found_out,
    output logic [KW-1:0]              link_value_out
);
    import bsrs_pkg::*;

    localparam int CMP_W = (CW > RANK_W) ? CW : RANK_W;

    logic [KW-1:0] key_reg;
    logic [KW-1:0] probe_reg;
    logic          probe_valid_reg;
    logic [CW-1:0] below_reg;
    logic          link_valid_reg;
    logic          link_found_reg;
    logic [KW-1:0] link_value_reg;

    logic entry_valid;
    logic key_hit;
    logic rank_hit;
    logic hit;
    logic prefix_found;

    always_comb
    begin
        entry_valid  = cell_index < held_count;
        key_hit      = entry_valid && (key_reg == cmd_key);
        rank_hit     = entry_valid && (CMP_W'(below_reg) == CMP_W'(rank_index));
        hit          = link_valid_in && (ctrl.rank_mode ? rank_hit : key_hit);
        prefix_found = link_found_in | hit;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.write && (cell_index == held_count))
        begin
            key_reg <= cmd_key;
        end
        else if (link_valid_in && ctrl.erase && prefix_found)
        begin
            key_reg <= right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.probe_load)
        begin
            probe_reg <= key_reg;
        end
        else if (ctrl.probe_shift)
        begin
            probe_reg <= probe_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_valid_reg <= 1'b0;
            below_reg       <= '0;
            link_valid_reg  <= 1'b0;
        end
        else
        begin
            link_valid_reg <= link_valid_in;
            if (ctrl.probe_load)
            begin
                probe_valid_reg <= entry_valid;
                below_reg       <= '0;
            end
            else if (ctrl.probe_shift)
            begin
                probe_valid_reg <= probe_valid_in;
                if (probe_valid_reg && (probe_reg < key_reg))
                begin
                    below_reg <= below_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_valid_in)
        begin
            link_found_reg <= prefix_found;
            link_value_reg <= hit ? key_reg : link_value_in;
        end
    end

    assign key_out         = key_reg;
    assign probe_out       = probe_reg;
    assign probe_valid_out = probe_valid_reg;
    assign link_valid_out  = link_valid_reg;
    assign link_found_out  = link_found_reg;
    assign link_value_out  = link_value_reg;

endmodule

// File: hw/rtl/bounded_set_with_rank_select.sv
// Bounded set with rank select: a fixed-capacity set of distinct keys held in a row of cells.
// Commands arrive on req, one result per command leaves on rsp.
// Depends on bsrs_pkg, bsrs_in_if, bsrs_out_if and bsrs_cell.
//
// Usage: a command (insert, erase, contains or get by rank) is taken on req when valid and
// ready are both high; ready is high only while no command is in progress. Each command
// gives exactly one result transfer on rsp with ok, the selected key for get (else zero)
// and the number of keys held after the command.
// Insert, erase and contains run one sweep through the row of cells, one cell per cycle.
// Get first circulates every stored key once around the row so that each cell counts the
// keys below its own, then sweeps. The next command is taken in the cycle after the result
// is registered, so a new command is never taken before the last one has its result.
// The result register holds while rsp.ready is low; the finished command waits in its last
// step until the result register is free, and no new command is taken meanwhile.
// Reset clears the key count and all control state; stored keys need no clearing.
module bounded_set_with_rank_select #(
    parameter int CAPACITY  = bsrs_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = bsrs_pkg::KEY_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bsrs_in_if.sink    req,
    bsrs_out_if.source rsp
);
    import bsrs_pkg::*;

    localparam int KW = KEY_WIDTH;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD   = 3'd1;
    localparam logic [2:0] S_COUNT  = 3'd2;
    localparam logic [2:0] S_START  = 3'd3;
    localparam logic [2:0] S_SWEEP  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [CMD_W-1:0]      cmd_reg;
    logic [KW-1:0]         key_reg;
    logic [RANK_W-1:0]     rank_reg;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         step_reg;
    logic                  found_reg;
    logic [KW-1:0]         value_reg;
    logic                  out_valid_reg;
    logic                  out_ok_reg;
    logic [PORT_KEY_W-1:0] out_value_reg;
    logic [COUNT_W-1:0]    out_count_reg;

    logic                  can_finish;
    logic                  ins_ok;
    logic                  res_ok;
    logic [PORT_KEY_W-1:0] res_value;
    bsrs_cell_ctrl_t       ctrl;

    logic [KW-1:0] cell_key   [CAPACITY];
    logic [KW-1:0] probe      [CAPACITY];
    logic          probe_vld  [CAPACITY];
    logic          link_valid [CAPACITY+1];
    logic          link_found [CAPACITY+1];
    logic [KW-1:0] link_value [CAPACITY+1];

    assign link_valid[0] = (state_reg == S_START);
    assign link_found[0] = 1'b0;
    assign link_value[0] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam int PREV  = (i == 0) ? CAPACITY - 1 : i - 1;
        localparam int RIGHT = (i == CAPACITY - 1) ? i : i + 1;

        bsrs_cell #(
            .KW(KW),
            .CW(CW)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctrl           (ctrl),
            .cmd_key        (key_reg),
            .rank_index     (rank_reg),
            .held_count     (count_reg),
            .cell_index     (CW'(i)),
            .right_key      (cell_key[RIGHT]),
            .key_out        (cell_key[i]),
            .probe_in       (probe[PREV]),
            .probe_valid_in (probe_vld[PREV]),
            .probe_out      (probe[i]),
            .probe_valid_out(probe_vld[i]),
            .link_valid_in  (link_valid[i]),
            .link_found_in  (link_found[i]),
            .link_value_in  (link_value[i]),
            .link_valid_out (link_valid[i+1]),
            .link_found_out (link_found[i+1]),
            .link_value_out (link_value[i+1])
        );
    end

    always_comb
    begin
        can_finish = (state_reg == S_FINISH) && (!out_valid_reg || rsp.ready);
        ins_ok     = !found_reg && (count_reg < CW'(CAPACITY));

        ctrl.probe_load  = (state_reg == S_LOAD);
        ctrl.probe_shift = (state_reg == S_COUNT);
        ctrl.erase       = (cmd_reg == CMD_ERASE);
        ctrl.rank_mode   = (cmd_reg == CMD_GET);
        ctrl.write       = can_finish && (cmd_reg == CMD_INSERT) && ins_ok;

        count_next = count_reg;
        res_value  = '0;
        case (cmd_reg)
            CMD_INSERT:
            begin
                res_ok = ins_ok;
                if (ins_ok)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_ERASE:
            begin
                res_ok = found_reg;
                if (found_reg)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            CMD_GET:
            begin
                res_ok    = found_reg;
                res_value = PORT_KEY_W'(value_reg);
            end
            default:
            begin
                res_ok = found_reg;
            end
        endcase

        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = (req.cmd == CMD_GET) ? S_LOAD : S_START;
                end
            end
            S_LOAD:
            begin
                state_next = S_COUNT;
            end
            S_COUNT:
            begin
                if (step_reg == CW'(CAPACITY - 1))
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                if (link_valid[CAPACITY])
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (can_finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_LOAD)
            begin
                step_reg <= '0;
            end
            else if (state_reg == S_COUNT)
            begin
                step_reg <= step_reg + CW'(1);
            end
            if (can_finish)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && req.valid)
        begin
            cmd_reg  <= req.cmd;
            key_reg  <= KW'(req.key);
            rank_reg <= req.rank_index;
        end
        if ((state_reg == S_SWEEP) && link_valid[CAPACITY])
        begin
            found_reg <= link_found[CAPACITY];
            value_reg <= link_value[CAPACITY];
        end
        if (can_finish)
        begin
            out_ok_reg    <= res_ok;
            out_value_reg <= res_value;
            out_count_reg <= COUNT_W'(count_next);
        end
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.ok         = out_ok_reg;
    assign rsp.item_value = out_value_reg;
    assign rsp.item_count = out_count_reg;

endmodule

// File: bench/bounded_set_with_rank_select_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the bounded set with rank select: directed and random commands
// with a built-in set predictor. Depends on bsrs_pkg, bsrs_in_if, bsrs_out_if and the RTL.
module bounded_set_with_rank_select_test;
    import bsrs_pkg::*;

    localparam int SLOTS         = CAPACITY_DEF;
    localparam int POOL_N        = 48;
    localparam int RANDOM_ITEMS  = 850;
    localparam int SETTLE_CYCLES = 2 * SLOTS + 40;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int ROWS          = 24;

    typedef struct packed {
        logic                  ok;
        logic [PORT_KEY_W-1:0] value;
        logic [COUNT_W-1:0]    count;
    } set_reply_t;

    typedef struct packed {
        logic [CMD_W-1:0]      cmd;
        logic [PORT_KEY_W-1:0] key;
        logic [RANK_W-1:0]     rank;
        logic                  typed;
        set_reply_t            reply;
    } step_row_t;

    logic clk = 1'b0;
    logic rst_n;

    bsrs_in_if  req_ch();
    bsrs_out_if rsp_ch();

    bounded_set_with_rank_select dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic [PORT_KEY_W-1:0] set_keys [SLOTS];
    int                    set_size = 0;
    set_reply_t            awaited_replies [$];
    int                    pending = 0;
    int                    failures = 0;
    int                    offered = 0;
    int                    results_seen = 0;
    int                    full_refusals = 0;
    int                    erase_hits = 0;
    logic [PORT_KEY_W-1:0] key_pool [POOL_N];

    step_row_t directed_rows [ROWS] = '{
        '{CMD_GET,      32'h0000_0000, 8'd0,   1'b1, '{1'b0, 32'h0000_0000, 6'd0}},
        '{CMD_CONTAINS, 32'h0000_0000, 8'd0,   1'b1, '{1'b0, 32'h0000_0000, 6'd0}},
        '{CMD_ERASE,    32'hFFFF_FFFF, 8'd255, 1'b1, '{1'b0, 32'h0000_0000, 6'd0}},
        '{CMD_INSERT,   32'h0000_0000, 8'd0,   1'b1, '{1'b1, 32'h0000_0000, 6'd1}},
        '{CMD_INSERT,   32'hFFFF_FFFF, 8'd255, 1'b1, '{1'b1, 32'h0000_0000, 6'd2}},
        '{CMD_INSERT,   32'h0000_0000, 8'd0,   1'b1, '{1'b0, 32'h0000_0000, 6'd2}},
        '{CMD_CONTAINS, 32'hFFFF_FFFF, 8'd0,   1'b1, '{1'b1, 32'h0000_0000, 6'd2}},
        '{CMD_CONTAINS, 32'h0000_0001, 8'd0,   1'b1, '{1'b0, 32'h0000_0000, 6'd2}},
        '{CMD_GET,      32'hFFFF_FFFF, 8'd0,   1'b1, '{1'b1, 32'h0000_0000, 6'd2}},
        '{CMD_GET,      32'h0000_0000, 8'd1,   1'b1, '{1'b1, 32'hFFFF_FFFF, 6'd2}},
        '{CMD_GET,      32'h0000_0000, 8'd2,   1'b1, '{1'b0, 32'h0000_0000, 6'd2}},
        '{CMD_GET,      32'h0000_0000, 8'd255, 1'b1, '{1'b0, 32'h0000_0000, 6'd2}},
        '{CMD_INSERT,   32'h8000_0000, 8'd0,   1'b1, '{1'b1, 32'h0000_0000, 6'd3}},
        '{CMD_INSERT,   32'h7FFF_FFFF, 8'd0,   1'b1, '{1'b1, 32'h0000_0000, 6'd4}},
        '{CMD_GET,      32'h0000_0000, 8'd2,   1'b1, '{1'b1, 32'h8000_0000, 6'd4}},
        '{CMD_ERASE,    32'h0000_0000, 8'd0,   1'b1, '{1'b1, 32'h0000_0000, 6'd3}},
        '{CMD_ERASE,    32'h0000_0000, 8'd0,   1'b1, '{1'b0, 32'h0000_0000, 6'd3}},
        '{CMD_GET,      32'h0000_0000, 8'd0,   1'b1, '{1'b1, 32'h7FFF_FFFF, 6'd3}},
        '{CMD_INSERT,   32'h5A5A_5A5A, 8'd170, 1'b0, '0},
        '{CMD_INSERT,   32'h0000_FFFF, 8'd85,  1'b0, '0},
        '{CMD_ERASE,    32'h7FFF_FFFF, 8'd0,   1'b0, '0},
        '{CMD_GET,      32'hA5A5_A5A5, 8'd3,   1'b0, '0},
        '{CMD_GET,      32'h0000_0000, 8'd4,   1'b1, '{1'b0, 32'h0000_0000, 6'd4}},
        '{CMD_CONTAINS, 32'h5A5A_5A5A, 8'd0,   1'b0, '0}
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic set_reply_t set_outcome(input logic [CMD_W-1:0] cmd,
                                               input logic [PORT_KEY_W-1:0] key,
                                               input logic [RANK_W-1:0] rank);
        set_reply_t reply;
        int         spot;
        int         below;
        reply = '0;
        spot = -1;
        for (int i = 0; i < set_size; i++)
        begin
            if (spot < 0 && set_keys[i] == key)
                spot = i;
        end
        case (cmd)
            CMD_INSERT:
            begin
                if (set_size < SLOTS && spot < 0)
                begin
                    set_keys[set_size] = key;
                    set_size++;
                    reply.ok = 1'b1;
                end
            end
            CMD_ERASE:
            begin
                if (spot >= 0)
                begin
                    for (int j = spot; j + 1 < set_size; j++)
                        set_keys[j] = set_keys[j + 1];
                    set_size--;
                    reply.ok = 1'b1;
                end
            end
            CMD_CONTAINS:
                reply.ok = (spot >= 0);
            default:
            begin
                if (int'(rank) < set_size)
                begin
                    for (int j = 0; j < set_size; j++)
                    begin
                        below = 0;
                        for (int k = 0; k < set_size; k++)
                        begin
                            if (set_keys[k] < set_keys[j])
                                below++;
                        end
                        if (!reply.ok && below == int'(rank))
                        begin
                            reply.ok = 1'b1;
                            reply.value = set_keys[j];
                        end
                    end
                end
            end
        endcase
        reply.count = COUNT_W'(set_size);
        return reply;
    endfunction

    task automatic offer_command(input logic [CMD_W-1:0] cmd,
                                 input logic [PORT_KEY_W-1:0] key,
                                 input logic [RANK_W-1:0] rank,
                                 input logic typed,
                                 input set_reply_t typed_reply);
        int         gap;
        set_reply_t predicted;
        gap = ((offered % 200) < 30) ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= cmd;
        req_ch.key        <= key;
        req_ch.rank_index <= rank;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (cmd == CMD_INSERT && set_size == SLOTS)
            full_refusals++;
        predicted = set_outcome(cmd, key, rank);
        if (cmd == CMD_ERASE && predicted.ok)
            erase_hits++;
        awaited_replies.push_back(typed ? typed_reply : predicted);
        pending++;
        offered++;
    endtask

    task automatic wait_until_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic check_reply();
        set_reply_t want;
        results_seen++;
        if (pending == 0)
        begin
            failures++;
            $display("%0t: result with nothing expected: ok %0b value %h count %0d",
                     $time, rsp_ch.ok, rsp_ch.item_value, rsp_ch.item_count);
        end
        else
        begin
            want = awaited_replies.pop_front();
            pending--;
            if (rsp_ch.ok !== want.ok)
            begin
                failures++;
                $display("%0t: ok mismatch, expected %0b, actual %0b",
                         $time, want.ok, rsp_ch.ok);
            end
            if (rsp_ch.item_value !== want.value)
            begin
                failures++;
                $display("%0t: item_value mismatch, expected %h, actual %h",
                         $time, want.value, rsp_ch.item_value);
            end
            if (rsp_ch.item_count !== want.count)
            begin
                failures++;
                $display("%0t: item_count mismatch, expected %0d, actual %0d",
                         $time, want.count, rsp_ch.item_count);
            end
        end
    endtask

    initial
    begin : result_sink
        int gap;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (results_seen == HOLD_AT)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = ((results_seen % 170) < 25) ? 0 : $urandom_range(0, 9);
                if (gap > 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            check_reply();
        end
    end

    initial
    begin : stimulus
        int                    lean;
        int                    pick;
        logic [CMD_W-1:0]      cmd;
        logic [PORT_KEY_W-1:0] key;
        logic [RANK_W-1:0]     rank;
        lean = 0;
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.cmd        <= CMD_INSERT;
        req_ch.key        <= '0;
        req_ch.rank_index <= '0;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7FFF_FFFF;
        key_pool[4] = 32'h0000_0001;
        for (int i = 5; i < POOL_N; i++)
            key_pool[i] = $urandom();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
            offer_command(directed_rows[r].cmd, directed_rows[r].key, directed_rows[r].rank,
                          directed_rows[r].typed, directed_rows[r].reply);
        wait_until_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 60 == 0)
                lean = $urandom_range(0, 2);
            if (i == RANDOM_ITEMS / 2)
                wait_until_drained();
            pick = $urandom_range(0, 99);
            case (lean)
                0: cmd = (pick < 55) ? CMD_INSERT : (pick < 65) ? CMD_ERASE :
                         (pick < 82) ? CMD_CONTAINS : CMD_GET;
                1: cmd = (pick < 20) ? CMD_INSERT : (pick < 60) ? CMD_ERASE :
                         (pick < 78) ? CMD_CONTAINS : CMD_GET;
                default: cmd = (pick < 35) ? CMD_INSERT : (pick < 60) ? CMD_ERASE :
                               (pick < 80) ? CMD_CONTAINS : CMD_GET;
            endcase
            key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_N - 1)]
                                               : $urandom();
            rank = ($urandom_range(0, 9) < 8) ? RANK_W'($urandom_range(0, set_size + 1))
                                              : RANK_W'($urandom_range(0, 255));
            offer_command(cmd, key, rank, 1'b0, '0);
        end

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Checked %0d results from %0d commands, including %0d successful erases.",
                 results_seen, offered, erase_hits);
        $display("Inserts refused on a full set: %0d; long result stall and drain pauses done.",
                 full_refusals);
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/bsrs_pkg.sv
hw/rtl/bsrs_in_if.sv
hw/rtl/bsrs_out_if.sv
hw/rtl/bsrs_cell.sv
hw/rtl/bounded_set_with_rank_select.sv
bench/bounded_set_with_rank_select_test.sv
